// File: src/ultrasonic_ranger_with_motor_interlock_unit_defines.svh
// Assertion macros for the ultrasonic ranger with motor interlock.
// Used by the top level only; every macro expects clk and rst in scope.
`ifndef ULTRASONIC_RANGER_WITH_MOTOR_INTERLOCK_UNIT_DEFINES_SVH
`define ULTRASONIC_RANGER_WITH_MOTOR_INTERLOCK_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define URMI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("urmi assertion failed");

// Next-cycle implication, checked outside reset.
`define URMI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("urmi assertion failed");

`endif

// File: src/urmi_pkg.sv
// Shared types and constants for the ultrasonic ranger with motor interlock.
// No dependencies; imported by every module of the block.
package urmi_pkg;

  localparam int SAMPLES_PER_AVERAGE = 5;

  localparam int TICK_W = 20;
  localparam int TIMEOUT_W = 16;
  localparam int STOP_W = 8;
  localparam int TRIG_W = 8;
  localparam int GAP_W = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  // Pulse width to centimeters: width * CM_NUM / CM_DEN, tracked incrementally.
  localparam int CM_NUM = 343;
  localparam int CM_DEN = 20000;
  localparam int REM_W = 15;
  localparam int CM_W = 11;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W = 12;
  localparam int AVG_W = 10;
  localparam int IDX_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_GAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_GAP = 3'd4;

  localparam logic [STOP_W-1:0] STOP_DISTANCE_RST = 8'd15;
  localparam logic [TIMEOUT_W-1:0] ECHO_TIMEOUT_RST = 16'd30000;
  localparam logic [TRIG_W-1:0] TRIGGER_WIDTH_RST = 8'd10;
  localparam logic [GAP_W-1:0] SAMPLE_GAP_RST = 20'd20000;
  localparam logic [GAP_W-1:0] ROUND_GAP_RST = 20'd200000;

  typedef struct packed {
    logic [STOP_W-1:0]    stop_distance;
    logic [TIMEOUT_W-1:0] echo_timeout;
    logic [TRIG_W-1:0]    trigger_width;
    logic [GAP_W-1:0]     sample_gap;
    logic [GAP_W-1:0]     round_gap;
  } urmi_cfg_t;

  // One finished sample, valid for the tick in which it ends.
  typedef struct packed {
    logic            done;
    logic            timed_out;
    logic [CM_W-1:0] cm;
  } urmi_sample_t;

endpackage

// File: src/urmi_seq.sv
// Trigger and echo timing sequencer: phase machine, tick counter, width-to-cm tracking.
// Depends on urmi_pkg.
module urmi_seq
  import urmi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic         echo,
  input  urmi_cfg_t    cfg,
  input  logic         last_sample,
  output logic         trig,
  output urmi_sample_t sample
);

  typedef enum logic [2:0] {
    PH_TRIG_LOW   = 3'd0,
    PH_TRIG_HIGH  = 3'd1,
    PH_WAIT_RISE  = 3'd2,
    PH_WAIT_FALL  = 3'd3,
    PH_SAMPLE_GAP = 3'd4,
    PH_ROUND_GAP  = 3'd5
  } phase_t;

  localparam logic [REM_W-1:0] REM_STEP = REM_W'(CM_NUM);
  localparam logic [REM_W-1:0] REM_DEN = REM_W'(CM_DEN);

  phase_t            phase, phase_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [REM_W-1:0]  rem, rem_next;
  logic [CM_W-1:0]   cm, cm_next;

  logic [TICK_W:0]   tick_inc;
  logic [REM_W-1:0]  rem_sum;
  logic [TICK_W-1:0] timeout_ext;
  logic [TICK_W:0]   trig_width_ext;
  logic [GAP_W-1:0]  gap_sel;
  logic [GAP_W-1:0]  gap_cur;
  logic              finish;

  assign tick_inc = {1'b0, tick_count} + (TICK_W+1)'(1);
  assign rem_sum = rem + REM_STEP;
  assign timeout_ext = TICK_W'(cfg.echo_timeout);
  assign trig_width_ext = (TICK_W+1)'(cfg.trigger_width);
  assign gap_sel = last_sample ? cfg.round_gap : cfg.sample_gap;
  assign gap_cur = (phase == PH_SAMPLE_GAP) ? cfg.sample_gap : cfg.round_gap;

  always_comb begin
    phase_next = phase;
    tick_count_next = tick_count;
    rem_next = rem;
    cm_next = cm;
    trig = 1'b0;
    finish = 1'b0;
    sample = '0;
    unique case (phase)
      PH_TRIG_HIGH: begin
        trig = 1'b1;
        tick_count_next = tick_inc[TICK_W-1:0];
        if (tick_inc >= trig_width_ext) begin
          phase_next = PH_WAIT_RISE;
          tick_count_next = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          // The rising tick is the first high tick of the pulse.
          phase_next = PH_WAIT_FALL;
          tick_count_next = TICK_W'(1);
          rem_next = REM_STEP;
          cm_next = '0;
        end else if (tick_count > timeout_ext) begin
          finish = 1'b1;
          sample.timed_out = 1'b1;
        end else begin
          tick_count_next = tick_inc[TICK_W-1:0];
        end
      end
      PH_WAIT_FALL: begin
        if (!echo) begin
          finish = 1'b1;
          sample.cm = cm;
        end else if (tick_count > timeout_ext) begin
          finish = 1'b1;
          sample.timed_out = 1'b1;
        end else begin
          // cm stays equal to floor(tick_count * 343 / 20000) as the count grows.
          tick_count_next = tick_inc[TICK_W-1:0];
          if (rem_sum >= REM_DEN) begin
            rem_next = rem_sum - REM_DEN;
            cm_next = cm + CM_W'(1);
          end else begin
            rem_next = rem_sum;
          end
        end
      end
      PH_SAMPLE_GAP, PH_ROUND_GAP: begin
        tick_count_next = tick_inc[TICK_W-1:0];
        if (tick_inc >= {1'b0, gap_cur}) begin
          phase_next = PH_TRIG_LOW;
          tick_count_next = '0;
        end
      end
      default: begin
        // Trigger low, and any code outside the machine.
        phase_next = PH_TRIG_LOW;
        tick_count_next = tick_inc[TICK_W-1:0];
        if (tick_inc >= trig_width_ext) begin
          phase_next = PH_TRIG_HIGH;
          tick_count_next = '0;
        end
      end
    endcase
    if (finish) begin
      sample.done = 1'b1;
      tick_count_next = '0;
      if (gap_sel == '0) begin
        phase_next = PH_TRIG_LOW;
      end else if (last_sample) begin
        phase_next = PH_ROUND_GAP;
      end else begin
        phase_next = PH_SAMPLE_GAP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TRIG_LOW;
      tick_count <= '0;
      rem <= '0;
      cm <= '0;
    end else if (step) begin
      phase <= phase_next;
      tick_count <= tick_count_next;
      rem <= rem_next;
      cm <= cm_next;
    end
  end

endmodule

// File: src/urmi_avg.sv
// Sample accumulator: saturating sum, sample index and published average.
// Depends on urmi_pkg.
module urmi_avg
  import urmi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  urmi_sample_t     sample,
  output logic             last_sample,
  output logic             published,
  output logic [AVG_W-1:0] average_next
);

  // Division by the sample count as a multiply by a rounded-up reciprocal;
  // exact for every sum of SUM_W bits and sample counts up to 16.
  localparam int RECIP_SHIFT = SUM_W + 4;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CM_W-1:0] SAMPLE_MAX = CM_W'((2 ** SAMPLE_W) - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_AVERAGE - 1);

  logic [SUM_W-1:0]         distance_sum, distance_sum_next;
  logic [IDX_W-1:0]         sample_index, sample_index_next;
  logic [AVG_W-1:0]         average_reg;

  logic [SAMPLE_W-1:0]      cm_sat;
  logic [SUM_W:0]           sum_raw;
  logic [SUM_W-1:0]         sum_sat;
  logic [SUM_W+RECIP_W-1:0] product;

  assign last_sample = (sample_index == IDX_LAST);
  assign cm_sat = (sample.cm > SAMPLE_MAX) ? SAMPLE_MAX[SAMPLE_W-1:0] : sample.cm[SAMPLE_W-1:0];
  assign sum_raw = {1'b0, distance_sum} + (SUM_W+1)'(cm_sat);
  assign sum_sat = sum_raw[SUM_W] ? SUM_MAX : sum_raw[SUM_W-1:0];
  assign product = (SUM_W+RECIP_W)'(sum_sat) * (SUM_W+RECIP_W)'(RECIP);
  assign published = sample.done && last_sample;

  always_comb begin
    distance_sum_next = distance_sum;
    sample_index_next = sample_index;
    average_next = average_reg;
    if (sample.done) begin
      if (last_sample) begin
        average_next = product[RECIP_SHIFT +: AVG_W];
        distance_sum_next = '0;
        sample_index_next = '0;
      end else begin
        distance_sum_next = sum_sat;
        sample_index_next = sample_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_sum <= '0;
      sample_index <= '0;
      average_reg <= '0;
    end else if (step) begin
      distance_sum <= distance_sum_next;
      sample_index <= sample_index_next;
      average_reg <= average_next;
    end
  end

endmodule

// File: src/ultrasonic_ranger_with_motor_interlock_unit.sv
// Top level of the ultrasonic ranger with motor interlock: handshakes, configuration
// registers, input and result registers. Depends on urmi_pkg, urmi_seq, urmi_avg and
// the assertion macro header.
//
// Usage: each input word is one microsecond tick carrying echo_level. The block
// answers every tick with one result word: trigger drive, motor enable, latest
// average distance in cm, and flags for a new average and a timed-out sample.
// Input channel: in_valid / in_stall / echo_level. A word is taken when in_valid
// is high and in_stall is low. Output channel: out_valid / out_stall and the
// result fields; the word moves when out_valid is high and out_stall is low.
// The input word waits in the input register; the ranging logic runs as it moves on
// into the result register, which raises out_valid.
// Throughput is one word per cycle while the receiver does not stall; the limit
// is the update of the phase counter and the running sum in each step. When the
// receiver stalls, the result register holds and one more word waits in the
// input register, after which in_stall rises until the result is taken.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready. The
// registers must be written only while no word is in flight; the block does not
// enforce this. Reset (rst, synchronous) restores the default register values,
// empties both pipeline registers and starts in the trigger-low phase, zero sum and average.
`include "ultrasonic_ranger_with_motor_interlock_unit_defines.svh"

module ultrasonic_ranger_with_motor_interlock_unit
  import urmi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  echo_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  trigger_level,
  output logic                  motor_enable,
  output logic [AVG_W-1:0]      distance_avg,
  output logic                  average_new,
  output logic                  sample_timed_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  urmi_cfg_t        cfg;
  logic             in_full;
  logic             echo_q;
  logic             out_ready;
  logic             step;
  logic             trig;
  logic             last_sample;
  logic             published;
  logic [AVG_W-1:0] average_next;
  logic             run;
  urmi_sample_t     sample;

  assign cfg_ready = 1'b1;
  assign out_ready = !out_valid || !out_stall;
  assign step = in_full && out_ready;
  assign in_stall = in_full && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_distance <= STOP_DISTANCE_RST;
      cfg.echo_timeout <= ECHO_TIMEOUT_RST;
      cfg.trigger_width <= TRIGGER_WIDTH_RST;
      cfg.sample_gap <= SAMPLE_GAP_RST;
      cfg.round_gap <= ROUND_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STOP_DISTANCE: cfg.stop_distance <= cfg_data[STOP_W-1:0];
        REG_ECHO_TIMEOUT:  cfg.echo_timeout <= cfg_data[TIMEOUT_W-1:0];
        REG_TRIGGER_WIDTH: cfg.trigger_width <= cfg_data[TRIG_W-1:0];
        REG_SAMPLE_GAP:    cfg.sample_gap <= cfg_data[GAP_W-1:0];
        REG_ROUND_GAP:     cfg.round_gap <= cfg_data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      echo_q <= echo_level;
    end
  end

  urmi_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .echo        (echo_q),
    .cfg         (cfg),
    .last_sample (last_sample),
    .trig        (trig),
    .sample      (sample)
  );

  urmi_avg u_avg (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .sample       (sample),
    .last_sample  (last_sample),
    .published    (published),
    .average_next (average_next)
  );

  // A nonzero average below the stop distance stops the motor.
  assign run = !((average_next != '0) && (average_next < AVG_W'(cfg.stop_distance)));

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      trigger_level <= trig;
      motor_enable <= run;
      distance_avg <= average_next;
      average_new <= published;
      sample_timed_out <= sample.timed_out;
    end
  end

  `URMI_ASSERT_IMPL(a_stop_needs_close_avg, out_valid && !motor_enable,
    (distance_avg != '0) && (distance_avg < AVG_W'(cfg.stop_distance)))
  `URMI_ASSERT_IMPL(a_publish_trigger_low, out_valid && average_new, !trigger_level)
  `URMI_ASSERT_IMPL(a_held_word_means_stall, in_full && !step, out_valid && out_stall)
  `URMI_ASSERT_NEXT(a_step_fills_output, step, out_valid)

endmodule
